// ===== rtl/core/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants for the tape language interpreter
// Sizes, command characters, request and fault codes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TAPE_DEPTH = 1024;
  localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
  localparam int CODE_DEPTH = 1024;
  localparam int CODE_AW    = $clog2(CODE_DEPTH);
  localparam int PC_W       = CODE_AW + 1;
  localparam int LEN_W      = 11;
  localparam int LOOP_DEPTH = 128;
  localparam int LOOP_AW    = $clog2(LOOP_DEPTH);
  localparam int DEPTH_W    = LOOP_AW + 1;
  localparam int CELL_BITS  = 8;
  localparam int BYTE_W     = 8;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_USER_W = 5;

  // command characters
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;  // '.'
  localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;  // ','
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;  // ']'

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EXEC    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    FLT_OK        = 2'd0,
    FLT_PTR       = 2'd1,
    FLT_STACK     = 2'd2,
    FLT_UNMATCHED = 2'd3
  } fault_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic ready;
    logic exec;
    logic scan_rd;
    logic scan_chk;
    logic clear_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic scan_start;
    logic scan_done;
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/tli_ctrl.sv =====
// ----------------------------------------------------------------------------
// tli_ctrl: sequencing state machine
// Walks each request through execute and result, with a bracket scan or a tape clear between them where needed.
// ----------------------------------------------------------------------------
module tli_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  tli_pkg::stat_t  stat,
  output tli_pkg::cmd_t   cmd
);

  tli_pkg::state_t state, state_next;
  logic restart_pend, restart_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tli_pkg::ST_CLEAR;
      restart_pend <= 1'b0;
    end else begin
      state        <= state_next;
      restart_pend <= restart_pend_next;
    end
  end

  always_comb begin
    state_next        = state;
    restart_pend_next = restart_pend;
    unique case (state)
      tli_pkg::ST_CLEAR: begin
        if (stat.clear_last) begin
          state_next        = restart_pend ? tli_pkg::ST_RESULT : tli_pkg::ST_IDLE;
          restart_pend_next = 1'b0;
        end
      end
      tli_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tli_pkg::ST_EXEC;
      end
      tli_pkg::ST_EXEC: begin
        if (stat.req == tli_pkg::REQ_RESTART) begin
          state_next        = tli_pkg::ST_CLEAR;
          restart_pend_next = 1'b1;
        end else if (stat.scan_start) begin
          state_next = tli_pkg::ST_SCAN_RD;
        end else begin
          state_next = tli_pkg::ST_RESULT;
        end
      end
      tli_pkg::ST_SCAN_RD:  state_next = tli_pkg::ST_SCAN_CHK;
      tli_pkg::ST_SCAN_CHK: begin
        state_next = stat.scan_done ? tli_pkg::ST_RESULT : tli_pkg::ST_SCAN_RD;
      end
      tli_pkg::ST_RESULT: begin
        if (stat.out_free) state_next = tli_pkg::ST_IDLE;
      end
      default: state_next = tli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      tli_pkg::ST_CLEAR:    cmd.clear_en = 1'b1;
      tli_pkg::ST_IDLE:     cmd.ready    = 1'b1;
      tli_pkg::ST_EXEC:     cmd.exec     = 1'b1;
      tli_pkg::ST_SCAN_RD:  cmd.scan_rd  = 1'b1;
      tli_pkg::ST_SCAN_CHK: cmd.scan_chk = 1'b1;
      tli_pkg::ST_RESULT:   cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/tli_dp.sv =====
// ----------------------------------------------------------------------------
// tli_dp: interpreter datapath
// Code store, tape, return stack, run registers and the result register.
// ----------------------------------------------------------------------------
module tli_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  tli_pkg::cmd_t                  cmd,
  output tli_pkg::stat_t                 stat,
  input  logic                           s_tvalid,
  input  logic [tli_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tli_pkg::BYTE_W-1:0]     m_tdata,
  output logic [tli_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                           cfg_valid,
  input  logic [tli_pkg::LEN_W-1:0]      cfg_data
);

  // memories
  logic [tli_pkg::BYTE_W-1:0]    code_mem  [tli_pkg::CODE_DEPTH];
  logic [tli_pkg::CELL_BITS-1:0] tape_mem  [tli_pkg::TAPE_DEPTH];
  logic [tli_pkg::CODE_AW-1:0]   stack_mem [tli_pkg::LOOP_DEPTH];

  logic [tli_pkg::BYTE_W-1:0]    code_q;
  logic [tli_pkg::CELL_BITS-1:0] tape_q;
  logic [tli_pkg::CODE_AW-1:0]   stack_q;

  // request fields
  tli_pkg::req_t                req_q;
  logic [tli_pkg::CODE_AW-1:0]  caddr_q;
  logic [tli_pkg::BYTE_W-1:0]   cbyte_q;
  logic [tli_pkg::CELL_BITS-1:0] inb_q;

  // run state
  logic [tli_pkg::PC_W-1:0]    pc, pc_next;
  logic [tli_pkg::TAPE_AW-1:0] ptr, ptr_next;
  logic [tli_pkg::DEPTH_W-1:0] depth, depth_next;
  tli_pkg::fault_t             fault, fault_next;
  logic [tli_pkg::LEN_W-1:0]   prog_len;
  logic [tli_pkg::TAPE_AW-1:0] clr_cnt;

  logic [tli_pkg::PC_W-1:0]    scan_addr;
  logic [tli_pkg::PC_W-1:0]    nest;

  logic                        ov_q, iu_q;
  logic [tli_pkg::BYTE_W-1:0]  ob_q;

  logic                          accept, halted, cell_zero;
  logic [tli_pkg::LEN_W-1:0]     len;
  logic [tli_pkg::PC_W-1:0]      pc_inc;
  logic                          tape_we, code_we, push, set_ov, set_iu, scan_init;
  logic [tli_pkg::TAPE_AW-1:0]   tape_wa;
  logic [tli_pkg::CELL_BITS-1:0] tape_wd;
  logic [tli_pkg::CODE_AW-1:0]   code_ra;
  logic [tli_pkg::LOOP_AW-1:0]   stack_ra;
  logic                          scan_end, scan_match;

  assign accept    = cmd.ready & s_tvalid;
  assign len       = (prog_len > tli_pkg::LEN_W'(tli_pkg::CODE_DEPTH))
                     ? tli_pkg::LEN_W'(tli_pkg::CODE_DEPTH) : prog_len;
  assign halted    = (fault != tli_pkg::FLT_OK) || (pc >= len);
  assign cell_zero = (tape_q == '0);
  assign pc_inc    = pc + tli_pkg::PC_W'(1);
  assign code_ra   = cmd.scan_rd ? scan_addr[tli_pkg::CODE_AW-1:0] : pc[tli_pkg::CODE_AW-1:0];
  assign stack_ra  = depth[tli_pkg::LOOP_AW-1:0] - tli_pkg::LOOP_AW'(1);
  assign scan_end   = (scan_addr >= len);
  assign scan_match = (code_q == tli_pkg::CH_CLOSE) && (nest == tli_pkg::PC_W'(1));

  always_comb begin
    pc_next    = pc;
    ptr_next   = ptr;
    depth_next = depth;
    fault_next = fault;
    tape_we    = 1'b0;
    tape_wa    = ptr;
    tape_wd    = '0;
    code_we    = 1'b0;
    push       = 1'b0;
    set_ov     = 1'b0;
    set_iu     = 1'b0;
    scan_init  = 1'b0;
    if (cmd.clear_en) begin
      tape_we = 1'b1;
      tape_wa = clr_cnt;
    end
    if (cmd.exec) begin
      unique case (req_q)
        tli_pkg::REQ_LOAD: code_we = 1'b1;
        tli_pkg::REQ_RESTART: begin
          pc_next    = '0;
          ptr_next   = '0;
          depth_next = '0;
          fault_next = tli_pkg::FLT_OK;
        end
        tli_pkg::REQ_EXEC: begin
          if (!halted) begin
            pc_next = pc_inc;
            case (code_q)
              tli_pkg::CH_RIGHT: begin
                if (ptr == tli_pkg::TAPE_AW'(tli_pkg::TAPE_DEPTH - 1)) begin
                  fault_next = tli_pkg::FLT_PTR;
                  pc_next    = pc;
                end else begin
                  ptr_next = ptr + tli_pkg::TAPE_AW'(1);
                end
              end
              tli_pkg::CH_LEFT: begin
                if (ptr == '0) begin
                  fault_next = tli_pkg::FLT_PTR;
                  pc_next    = pc;
                end else begin
                  ptr_next = ptr - tli_pkg::TAPE_AW'(1);
                end
              end
              tli_pkg::CH_INC: begin
                tape_we = 1'b1;
                tape_wd = tape_q + tli_pkg::CELL_BITS'(1);
              end
              tli_pkg::CH_DEC: begin
                tape_we = 1'b1;
                tape_wd = tape_q - tli_pkg::CELL_BITS'(1);
              end
              tli_pkg::CH_OUT: set_ov = 1'b1;
              tli_pkg::CH_IN: begin
                tape_we = 1'b1;
                tape_wd = inb_q;
                set_iu  = 1'b1;
              end
              tli_pkg::CH_OPEN: begin
                if (cell_zero) begin
                  scan_init = 1'b1;
                  pc_next   = pc;
                end else if (depth >= tli_pkg::DEPTH_W'(tli_pkg::LOOP_DEPTH)) begin
                  fault_next = tli_pkg::FLT_STACK;
                  pc_next    = pc;
                end else begin
                  push       = 1'b1;
                  depth_next = depth + tli_pkg::DEPTH_W'(1);
                end
              end
              tli_pkg::CH_CLOSE: begin
                if (depth == '0) begin
                  fault_next = tli_pkg::FLT_UNMATCHED;
                  pc_next    = pc;
                end else if (!cell_zero) begin
                  pc_next = {1'b0, stack_q} + tli_pkg::PC_W'(1);
                end else begin
                  depth_next = depth - tli_pkg::DEPTH_W'(1);
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
    if (cmd.scan_chk) begin
      if (scan_end) pc_next = len;
      else if (scan_match) pc_next = scan_addr + tli_pkg::PC_W'(1);
    end
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (code_we) code_mem[caddr_q] <= cbyte_q;
    code_q <= code_mem[code_ra];
  end

  always_ff @(posedge clk) begin
    if (tape_we) tape_mem[tape_wa] <= tape_wd;
    tape_q <= tape_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (push) stack_mem[depth[tli_pkg::LOOP_AW-1:0]] <= pc[tli_pkg::CODE_AW-1:0];
    stack_q <= stack_mem[stack_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      ptr      <= '0;
      depth    <= '0;
      fault    <= tli_pkg::FLT_OK;
      prog_len <= '0;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      pc    <= pc_next;
      ptr   <= ptr_next;
      depth <= depth_next;
      fault <= fault_next;
      if (cfg_valid) prog_len <= cfg_data;
      if (cmd.exec && req_q == tli_pkg::REQ_RESTART) clr_cnt <= '0;
      else if (cmd.clear_en) clr_cnt <= clr_cnt + tli_pkg::TAPE_AW'(1);
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= tli_pkg::req_t'(s_tuser);
      caddr_q <= s_tdata[9:0];
      cbyte_q <= s_tdata[17:10];
      inb_q   <= s_tdata[25:18];
      ov_q    <= 1'b0;
      ob_q    <= '0;
      iu_q    <= 1'b0;
    end
    if (set_ov) begin
      ov_q <= 1'b1;
      ob_q <= tape_q[tli_pkg::BYTE_W-1:0];
    end
    if (set_iu) iu_q <= 1'b1;
    if (scan_init) begin
      scan_addr <= pc_inc;
      nest      <= tli_pkg::PC_W'(1);
    end else if (cmd.scan_chk && !scan_end && !scan_match) begin
      scan_addr <= scan_addr + tli_pkg::PC_W'(1);
      if (code_q == tli_pkg::CH_OPEN) nest <= nest + tli_pkg::PC_W'(1);
      else if (code_q == tli_pkg::CH_CLOSE) nest <= nest - tli_pkg::PC_W'(1);
    end
    if (cmd.out_load) begin
      m_tdata <= ob_q;
      m_tuser <= {fault, halted, iu_q, ov_q};
    end
  end

  always_comb begin
    stat.req        = req_q;
    stat.scan_start = scan_init;
    stat.scan_done  = scan_end | scan_match;
    stat.clear_last = (clr_cnt == tli_pkg::TAPE_AW'(tli_pkg::TAPE_DEPTH - 1));
    stat.out_free   = ~m_tvalid | m_tready;
  end

endmodule

// ===== rtl/core/tape_language_interpreter_core.sv =====
// ----------------------------------------------------------------------------
// tape_language_interpreter_core: eight-command tape language interpreter
// Code store, 1024-cell tape and loop stack behind a request/result stream.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. A request is a load (write one
// program byte), an execute (run the instruction at the program counter) or
// a restart (rewind the run and zero the tape; the program is kept). A load,
// an unused request or a plain instruction passes through accept, execute
// (code byte, cell and stack top are read from their memories at the
// accepting edge, while the block waits idle), and result. The result state
// waits while the output register is full; the result is loaded as it leaves
// it and the block returns to idle, ready for the next request. A '[' over a
// zero cell walks the code store for its match, each scanned byte read in a
// scan-read state and checked in a scan-check state, one code-store read port
// being shared with fetch. A restart runs a tape clear, one cell a cycle,
// before its result. After reset the same clear runs with s_tready low;
// configuration writes are taken at any time and should be made while the
// block is idle. The output register holds a result until taken, so the next
// request is accepted meanwhile. Faults (pointer off either end, loop stack
// overflow past 128, unmatched ']') stop the run until a restart.
// ----------------------------------------------------------------------------
module tape_language_interpreter_core (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tli_pkg::IN_TDATA_W-1:0] s_tdata,  // code_addr[9:0], code_byte, in_byte
  input  logic [1:0]                     s_tuser,  // req_type
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tli_pkg::BYTE_W-1:0]     m_tdata,  // out_byte
  output logic [tli_pkg::OUT_USER_W-1:0] m_tuser,  // out_valid, input_used, halted, status[1:0]
  // program length register
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tli_pkg::LEN_W-1:0]      cfg_data
);

  tli_pkg::cmd_t  cmd;
  tli_pkg::stat_t stat;

  // register always writable
  assign cfg_ready = 1'b1;
  assign s_tready  = cmd.ready;

  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  tli_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

  // a nonzero fault always reports as halted
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[4:3] != tli_pkg::FLT_OK) |-> m_tuser[2])
    else $error("fault reported without halt");

  // one instruction cannot both emit and consume
  a_out_in_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("output and input flagged together");

  // out_byte is zero unless an output command ran
  a_out_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
    else $error("stray output byte");

  // one request at a time: no acceptance in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("back-to-back acceptance");

endmodule

// ===== dv/tb_tape_language_interpreter_core.sv =====
// ----------------------------------------------------------------------------
// tb_tape_language_interpreter_core: self-checking bench for the interpreter
// Streams load, execute, restart and unused requests into the core, predicts
// each result with an in-bench interpreter and checks the result stream in
// order. Short hand-built programs cover wrap, I/O, loops and every fault;
// random, mostly bracket-balanced programs run under changing back-pressure after.
// ----------------------------------------------------------------------------
module tb_tape_language_interpreter_core;
  import tli_pkg::*;

  localparam int STALL_LIMIT = 20000;  // quiet cycles before giving up
  localparam logic [BYTE_W-1:0] NOP_BYTE = 8'h20;

  typedef struct {
    req_t              kind;
    logic [CODE_AW-1:0] addr;
    logic [BYTE_W-1:0]  code;
    logic [BYTE_W-1:0]  data;
  } tape_req_t;

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              input_used;
    logic              halted;
    fault_t            status;
  } step_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [BYTE_W-1:0]     m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LEN_W-1:0]      cfg_data = '0;

  tape_language_interpreter_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial forever #5 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Interpreter state mirrored by the bench
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]    code_mem [CODE_DEPTH];
  logic [CELL_BITS-1:0] tape     [TAPE_DEPTH];
  logic [TAPE_AW-1:0]   tape_ptr;
  logic [PC_W-1:0]      run_pc;
  logic [CODE_AW-1:0]   loop_stack [LOOP_DEPTH];
  int unsigned          loop_depth;
  fault_t               fault;
  logic [LEN_W-1:0]     prog_len = '0;

  tape_req_t    pending_requests [$];
  step_result_t expected_results [$];
  tape_req_t    offered;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  bit           hold_go = 1'b0;
  logic         rx_hold = 1'b0;
  int           mismatches = 0;
  int           results_seen = 0;
  int           quiet_cycles = 0;

  function automatic void clear_run_state();
    foreach (tape[i]) tape[i] = '0;
    tape_ptr   = '0;
    run_pc     = '0;
    loop_depth = 0;
    fault      = FLT_OK;
  endfunction

  // Applies one request to the mirrored state and returns the result it gives.
  function automatic step_result_t interpret_request(tape_req_t r);
    step_result_t         res;
    logic [PC_W-1:0]      eff_len;
    logic [TAPE_AW-1:0]   here;
    logic [CELL_BITS-1:0] cur_cell;
    logic [PC_W-1:0]      scan_at;
    int                   nest;
    bit                   found;
    bit                   advance;
    res = '0;
    eff_len = (prog_len > LEN_W'(CODE_DEPTH)) ? PC_W'(CODE_DEPTH) : PC_W'(prog_len);
    case (r.kind)
      REQ_LOAD: code_mem[r.addr] = r.code;
      REQ_EXEC: begin
        if (fault == FLT_OK && run_pc < eff_len) begin
          here     = tape_ptr;
          cur_cell = tape[here];
          advance  = 1'b1;
          case (code_mem[run_pc[CODE_AW-1:0]])
            CH_RIGHT: begin
              if (here == TAPE_AW'(TAPE_DEPTH - 1)) begin
                fault   = FLT_PTR;
                advance = 1'b0;
              end else begin
                tape_ptr = here + 1'b1;
              end
            end
            CH_LEFT: begin
              if (here == '0) begin
                fault   = FLT_PTR;
                advance = 1'b0;
              end else begin
                tape_ptr = here - 1'b1;
              end
            end
            CH_INC: tape[here] = cur_cell + 1'b1;
            CH_DEC: tape[here] = cur_cell - 1'b1;
            CH_OUT: begin
              res.out_valid = 1'b1;
              res.out_byte  = cur_cell[BYTE_W-1:0];
            end
            CH_IN: begin
              tape[here]     = r.data;
              res.input_used = 1'b1;
            end
            CH_OPEN: begin
              advance = 1'b0;
              if (cur_cell == '0) begin
                // skip forward past the matching close, or to the end
                nest    = 1;
                found   = 1'b0;
                scan_at = run_pc + 1'b1;
                while (scan_at < eff_len && !found) begin
                  if (code_mem[scan_at[CODE_AW-1:0]] == CH_OPEN) begin
                    nest++;
                  end else if (code_mem[scan_at[CODE_AW-1:0]] == CH_CLOSE) begin
                    nest--;
                    if (nest == 0) found = 1'b1;
                  end
                  if (!found) scan_at++;
                end
                run_pc = found ? scan_at + 1'b1 : eff_len;
              end else if (loop_depth >= LOOP_DEPTH) begin
                fault = FLT_STACK;
              end else begin
                loop_stack[loop_depth] = run_pc[CODE_AW-1:0];
                loop_depth++;
                advance = 1'b1;
              end
            end
            CH_CLOSE: begin
              if (loop_depth == 0) begin
                fault   = FLT_UNMATCHED;
                advance = 1'b0;
              end else if (cur_cell != '0) begin
                run_pc  = {1'b0, loop_stack[loop_depth - 1]} + 1'b1;
                advance = 1'b0;
              end else begin
                loop_depth--;
              end
            end
            default: ;
          endcase
          if (advance) run_pc = run_pc + 1'b1;
        end
      end
      REQ_RESTART: clear_run_state();
      default: ;
    endcase
    res.halted = (fault != FLT_OK) || (run_pc >= eff_len);
    res.status = fault;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver: one request in flight on the slave side at a time
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      clear_run_state();
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(interpret_request(offered));
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered  <= pending_requests[0];
          s_tdata  <= {6'b0, pending_requests[0].data, pending_requests[0].code,
                       pending_requests[0].addr};
          s_tuser  <= pending_requests[0].kind;
          s_tvalid <= 1'b1;
          void'(pending_requests.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    step_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (m_tuser[0] !== want.out_valid)
            report_mismatch($sformatf("out_valid %b, expected %b", m_tuser[0], want.out_valid));
          if (m_tdata !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h", m_tdata, want.out_byte));
          if (m_tuser[1] !== want.input_used)
            report_mismatch($sformatf("input_used %b, expected %b", m_tuser[1],
                                      want.input_used));
          if (m_tuser[2] !== want.halted)
            report_mismatch($sformatf("halted %b, expected %b", m_tuser[2], want.halted));
          if (m_tuser[4:3] !== want.status)
            report_mismatch($sformatf("status %0d, expected %s", m_tuser[4:3],
                                      want.status.name()));
        end
        results_seen++;
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver hold-off so that the output register and input back up
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_request(req_t kind, logic [CODE_AW-1:0] addr, logic [BYTE_W-1:0] code,
                               logic [BYTE_W-1:0] data);
    tape_req_t r;
    r.kind = kind;
    r.addr = addr;
    r.code = code;
    r.data = data;
    pending_requests.push_back(r);
  endtask

  task automatic queue_load(logic [CODE_AW-1:0] addr, logic [BYTE_W-1:0] code);
    queue_request(REQ_LOAD, addr, code, BYTE_W'($urandom));
  endtask

  task automatic queue_exec(logic [BYTE_W-1:0] data);
    queue_request(REQ_EXEC, CODE_AW'($urandom), BYTE_W'($urandom), data);
  endtask

  task automatic queue_restart();
    queue_request(REQ_RESTART, CODE_AW'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  // sender stops until every request has its result, then lets the core settle;
  // checked between edges so the driver's updates at the edge have landed
  task automatic drain_all();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(logic [LEN_W-1:0] len);
    drain_all();
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    prog_len = len;
  endtask

  initial begin
    logic [BYTE_W-1:0] basic_prog [14];
    logic [BYTE_W-1:0] ch;
    logic [LEN_W-1:0]  run_len;
    int                random_sent;
    int                round;
    int                gen_len;
    int                opened;
    int                pick;
    int                n_exec;
    bit                balanced;

    // wrap both ways, output, input, a counted loop, a skipped loop, and a
    // pointer fault off the left end of the tape
    basic_prog = '{CH_DEC, CH_OUT, NOP_BYTE, CH_INC, CH_IN, CH_OPEN, CH_DEC, CH_CLOSE,
                   CH_RIGHT, CH_OPEN, CH_OUT, CH_CLOSE, CH_LEFT, CH_LEFT};

    do @(posedge clk);
    while (rst);
    tx_idle_pct = 17;
    rx_idle_pct = 76;

    // length still zero: execute is halted, unused request only reports
    queue_exec(8'hFF);
    queue_request(REQ_NONE, '1, '1, '1);
    foreach (basic_prog[i]) queue_load(CODE_AW'(i), basic_prog[i]);
    write_length(LEN_W'(14));
    repeat (15) queue_exec(8'h02);

    // close bracket with an empty loop stack
    queue_load('0, CH_CLOSE);
    queue_restart();
    queue_exec(8'h00);
    queue_exec(8'h00);

    // one more open than the loop stack holds
    queue_load('0, CH_INC);
    for (int i = 1; i <= LOOP_DEPTH + 1; i++) queue_load(CODE_AW'(i), CH_OPEN);
    write_length(LEN_W'(LOOP_DEPTH + 2));
    queue_restart();
    repeat (LOOP_DEPTH + 2) queue_exec(BYTE_W'($urandom));

    // random programs; runs stay within the first LOOP_DEPTH + 2 entries,
    // all of which are loaded above
    random_sent = 0;
    round = 0;
    while (random_sent < 700) begin
      if (random_sent < 200) begin
        tx_idle_pct = 17;
        rx_idle_pct = 76;
      end else if (random_sent < 450) begin
        tx_idle_pct = 76;
        rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      gen_len  = (round == 0) ? 40 : $urandom_range(40, 3);
      balanced = ($urandom_range(5) != 0);
      opened   = 0;
      for (int i = 0; i < gen_len; i++) begin
        pick = $urandom_range(99);
        if (balanced && opened > 0 && gen_len - i <= opened) ch = CH_CLOSE;
        else if (pick < 10 && (!balanced || gen_len - i > opened + 2)) ch = CH_OPEN;
        else if (pick < 20 && (opened > 0 || !balanced)) ch = CH_CLOSE;
        else if (pick < 32) ch = CH_RIGHT;
        else if (pick < 38) ch = CH_LEFT;
        else if (pick < 55) ch = CH_INC;
        else if (pick < 70) ch = CH_DEC;
        else if (pick < 82) ch = CH_OUT;
        else if (pick < 92) ch = CH_IN;
        else ch = BYTE_W'($urandom);
        if (ch == CH_OPEN) opened++;
        else if (ch == CH_CLOSE && opened > 0) opened--;
        queue_load(CODE_AW'(i), ch);
      end
      pick = $urandom_range(9);
      if (round == 1 || pick == 1) run_len = LEN_W'(LOOP_DEPTH + 2);
      else if (round == 2 || pick == 0) run_len = '0;
      else if (pick == 2) run_len = LEN_W'($urandom_range(LOOP_DEPTH + 2));
      else run_len = LEN_W'(gen_len);
      write_length(run_len);
      if (round == 0) hold_go = 1'b1;
      queue_restart();
      n_exec = (round == 0) ? 150 : $urandom_range(3 * gen_len + 8, gen_len);
      for (int k = 0; k < n_exec; k++) begin
        pick = $urandom_range(99);
        if (pick < 4) queue_load(CODE_AW'($urandom), BYTE_W'($urandom));
        else if (pick < 6) queue_request(REQ_NONE, CODE_AW'($urandom), BYTE_W'($urandom),
                                         BYTE_W'($urandom));
        else if (pick < 8) queue_restart();
        queue_exec(BYTE_W'($urandom));
      end
      random_sent += gen_len + n_exec + 1;
      round++;
    end

    drain_all();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tli_pkg.sv
rtl/core/tli_ctrl.sv
rtl/core/tli_dp.sv
rtl/core/tape_language_interpreter_core.sv
dv/tb_tape_language_interpreter_core.sv
